### src/ordered_list_engine_top_macros.svh
// Assertion macros used by the ordered list engine checker.
`ifndef ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`define ORDERED_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### src/ole_pkg.sv
// Package with the operation codes and sequencer states of the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;

  typedef enum logic [2:0] {
    K_CLEAR    = 3'd0,
    K_ADD_HEAD = 3'd1,
    K_ADD_TAIL = 3'd2,
    K_ADD_AT   = 3'd3,
    K_FIND     = 3'd4,
    K_REMOVE   = 3'd5,
    K_DUMP     = 3'd6,
    K_DUMP_REV = 3'd7
  } kind_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CHK  = 6'b000100,
    S_NODE = 6'b001000,
    S_LINK = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

endpackage

### src/ole_in_if.sv
// Input channel of the ordered list engine: one operation per item.
`timescale 1ns / 1ps
interface ole_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] value;
  logic [6:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

### src/ole_out_if.sv
// Output channel of the ordered list engine: one result per item.
`timescale 1ns / 1ps
interface ole_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] item_value;
  logic [6:0]         found_position;
  logic [6:0]         list_length;
  logic               last;

  modport source (output valid, status, item_value, found_position, list_length, last,
                  input ready);
  modport sink   (input valid, status, item_value, found_position, list_length, last,
                  output ready);
endinterface

### src/ole_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ordered_list_engine_top.sv
// Ordered list engine: a doubly linked list of signed values in a fixed entry pool.
// Clear and a dropped add go straight to the result state; add at head or tail writes the
// new node, then relinks its neighbour, then emits. Find, remove, add at an inner position
// and dumps walk the list, per entry one read of the value/link RAMs, then one compare.
// One operation is in flight at a time; a finished result waits in the output register.
// Reset empties the list at once; the memories are not cleared.
`timescale 1ns / 1ps
module ordered_list_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ole_in_if.sink    in_i,
  ole_out_if.source out_o
);
  import ole_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(CAPACITY + 2);
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  function automatic logic vld(input logic [PW-1:0] x);
    return x < NIL;
  endfunction

  state_e state_q, state_d;
  kind_e  op_q, op_d;
  logic signed [31:0] val_q, val_d;
  logic [6:0] pos_q, pos_d;
  logic [PW-1:0] e_q, e_d, head_q, head_d, tail_q, tail_d, alloc_q, alloc_d;
  logic [CW-1:0] i_q, i_d, count_q, count_d, ef_fpos_q, ef_fpos_d;
  logic ef_status_q, ef_status_d;
  logic [PW-1:0] nn_q, nn_d, np_q, np_d;
  logic lne_q, lne_d, lpe_q, lpe_d;
  logic [PW-1:0] lna_q, lna_d, lnd_q, lnd_d, lpa_q, lpa_d, lpd_q, lpd_d;

  logic ov_q, o_status_q, o_last_q;
  logic signed [31:0] o_val_q;
  logic [6:0] o_fpos_q, o_len_q;
  logic load_out, lo_status, lo_last;
  logic signed [31:0] lo_val;
  logic [6:0] lo_fpos;
  logic out_free;

  logic [31:0] rv;
  logic [PW-1:0] rn, rp, nx;
  logic next_we, prev_we;
  logic [AW-1:0] next_wa, prev_wa;
  logic [PW-1:0] next_wd, prev_wd;

  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign next_we = (state_q == S_NODE) || ((state_q == S_LINK) && lne_q);
  assign next_wa = (state_q == S_NODE) ? alloc_q[AW-1:0] : lna_q[AW-1:0];
  assign next_wd = (state_q == S_NODE) ? nn_q : lnd_q;
  assign prev_we = (state_q == S_NODE) || ((state_q == S_LINK) && lpe_q);
  assign prev_wa = (state_q == S_NODE) ? alloc_q[AW-1:0] : lpa_q[AW-1:0];
  assign prev_wd = (state_q == S_NODE) ? np_q : lpd_q;

  ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i, .we_i(state_q == S_NODE), .waddr_i(alloc_q[AW-1:0]), .wdata_i(val_q),
    .re_i(state_q == S_RD), .raddr_i(e_q[AW-1:0]), .rdata_o(rv)
  );
  ole_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .re_i(state_q == S_RD), .raddr_i(e_q[AW-1:0]), .rdata_o(rn)
  );
  ole_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .re_i(state_q == S_RD), .raddr_i(e_q[AW-1:0]), .rdata_o(rp)
  );

  assign nx = (op_q == K_DUMP_REV) ? rp : rn;

  always_comb begin
    logic [PW-1:0] start;
    state_d = state_q; op_d = op_q; val_d = val_q; pos_d = pos_q;
    e_d = e_q; i_d = i_q; head_d = head_q; tail_d = tail_q;
    alloc_d = alloc_q; count_d = count_q;
    ef_fpos_d = ef_fpos_q; ef_status_d = ef_status_q;
    nn_d = nn_q; np_d = np_q;
    lne_d = lne_q; lna_d = lna_q; lnd_d = lnd_q;
    lpe_d = lpe_q; lpa_d = lpa_q; lpd_d = lpd_q;
    load_out = 1'b0; lo_status = 1'b0; lo_val = '0; lo_fpos = '0; lo_last = 1'b1;
    start = head_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d = kind_e'(in_i.kind);
          val_d = in_i.value;
          pos_d = in_i.position;
          ef_fpos_d = '0;
          ef_status_d = 1'b0;
          e_d = head_q;
          i_d = CW'(1);
          lne_d = 1'b0;
          lpe_d = 1'b0;
          case (kind_e'(in_i.kind))
            K_CLEAR: begin
              head_d = NIL; tail_d = NIL; alloc_d = '0; count_d = '0;
              state_d = S_EMIT;
            end
            K_ADD_HEAD, K_ADD_TAIL, K_ADD_AT: begin
              if (alloc_q == NIL) begin
                ef_status_d = 1'b1;
                state_d = S_EMIT;
              end else if (kind_e'(in_i.kind) == K_ADD_HEAD ||
                           (kind_e'(in_i.kind) == K_ADD_AT && in_i.position == 7'd1 &&
                            int'(count_q) >= 1)) begin
                nn_d = head_q; np_d = NIL;
                lpe_d = vld(head_q); lpa_d = head_q; lpd_d = alloc_q;
                if (!vld(head_q)) tail_d = alloc_q;
                head_d = alloc_q;
                state_d = S_NODE;
              end else if (kind_e'(in_i.kind) == K_ADD_TAIL || in_i.position == 7'd0 ||
                           int'(in_i.position) > int'(count_q)) begin
                nn_d = NIL; np_d = tail_q;
                lne_d = vld(tail_q); lna_d = tail_q; lnd_d = alloc_q;
                if (!vld(tail_q)) head_d = alloc_q;
                tail_d = alloc_q;
                state_d = S_NODE;
              end else begin
                state_d = S_RD;
              end
            end
            default: begin
              if (kind_e'(in_i.kind) == K_DUMP_REV) start = tail_q;
              e_d = start;
              if (!vld(start)) begin
                if (kind_e'(in_i.kind) == K_FIND) ef_fpos_d = CW'(1);
                state_d = S_EMIT;
              end else begin
                state_d = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        case (op_q)
          K_FIND: begin
            if (rv == val_q) begin
              ef_fpos_d = i_q;
              state_d = S_EMIT;
            end else if (!vld(rn)) begin
              ef_fpos_d = i_q + CW'(1);
              state_d = S_EMIT;
            end else begin
              e_d = rn; i_d = i_q + CW'(1); state_d = S_RD;
            end
          end
          K_REMOVE: begin
            if (rv == val_q) begin
              lne_d = vld(rp); lna_d = rp; lnd_d = rn;
              if (!vld(rp)) head_d = rn;
              lpe_d = vld(rn); lpa_d = rn; lpd_d = rp;
              if (!vld(rn)) tail_d = rp;
              if (count_q != '0) count_d = count_q - CW'(1);
              state_d = S_LINK;
            end else if (!vld(rn)) begin
              state_d = S_EMIT;
            end else begin
              e_d = rn; state_d = S_RD;
            end
          end
          K_DUMP, K_DUMP_REV: begin
            if (out_free) begin
              load_out = 1'b1;
              lo_val = rv;
              lo_last = !vld(nx);
              if (vld(nx)) begin
                e_d = nx; state_d = S_RD;
              end else begin
                state_d = S_IDLE;
              end
            end
          end
          default: begin
            if (int'(i_q) + 1 == int'(pos_q)) begin
              nn_d = rn; np_d = e_q;
              lne_d = 1'b1; lna_d = e_q; lnd_d = alloc_q;
              lpe_d = vld(rn); lpa_d = rn; lpd_d = alloc_q;
              if (!vld(rn)) tail_d = alloc_q;
              state_d = S_NODE;
            end else begin
              e_d = rn; i_d = i_q + CW'(1); state_d = S_RD;
            end
          end
        endcase
      end
      S_NODE: begin
        alloc_d = alloc_q + PW'(1);
        count_d = count_q + CW'(1);
        state_d = S_LINK;
      end
      S_LINK: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          lo_status = ef_status_q;
          lo_fpos = 7'(ef_fpos_q);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= NIL;
      tail_q <= NIL;
      alloc_q <= '0;
      count_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      tail_q <= tail_d;
      alloc_q <= alloc_d;
      count_q <= count_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; val_q <= val_d; pos_q <= pos_d;
    e_q <= e_d; i_q <= i_d;
    ef_fpos_q <= ef_fpos_d; ef_status_q <= ef_status_d;
    nn_q <= nn_d; np_q <= np_d;
    lne_q <= lne_d; lna_q <= lna_d; lnd_q <= lnd_d;
    lpe_q <= lpe_d; lpa_q <= lpa_d; lpd_q <= lpd_d;
    if (load_out) begin
      o_status_q <= lo_status;
      o_val_q <= lo_val;
      o_fpos_q <= lo_fpos;
      o_last_q <= lo_last;
      o_len_q <= 7'(count_q);
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.status = o_status_q;
  assign out_o.item_value = o_val_q;
  assign out_o.found_position = o_fpos_q;
  assign out_o.list_length = o_len_q;
  assign out_o.last = o_last_q;

endmodule

### src/ole_checker.sv
// Port-level checker for the ordered list engine and its bind to the top level.
`timescale 1ns / 1ps
`include "ordered_list_engine_top_macros.svh"
module ole_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_status_i,
  input logic       out_last_i,
  input logic [6:0] out_fpos_i
);

  `OLE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `OLE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "item taken while busy")
  `OLE_ASSERT_NOW(a_drop_is_last, out_valid_i && out_status_i, out_last_i, "dropped add not final")
  `OLE_ASSERT_NOW(a_partial_dump, out_valid_i && !out_last_i, !out_status_i && out_fpos_i == 7'd0, "bad partial dump result")

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_i.valid),
  .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_status_i(out_o.status),
  .out_last_i(out_o.last),
  .out_fpos_i(out_o.found_position)
);

### test/ordered_list_engine_top_tb.sv
// Testbench for the ordered list engine: list operations checked against a behavioral list.
`timescale 1ns / 1ps
module ordered_list_engine_top_tb;
  import ole_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    logic               status;
    logic signed [31:0] item_value;
    logic [6:0]         found_position;
    logic [6:0]         list_length;
    logic               last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ole_in_if  op_ch ();
  ole_out_if res_ch ();

  ordered_list_engine_top #(.CAPACITY(CAP)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch.sink),
    .out_o (res_ch.source)
  );

  logic signed [31:0] list_vals[$];
  int                 pool_used;
  result_t            expected_results[$];
  int                 errors;
  int                 hold_cycles;
  logic signed [31:0] pool_vals[8];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic result_t mk_result(logic st, logic signed [31:0] v, int fp, logic lst);
    result_t r;
    r.status = st;
    r.item_value = v;
    r.found_position = fp[6:0];
    r.list_length = 7'(list_vals.size());
    r.last = lst;
    return r;
  endfunction

  // Applies one operation to the list and queues the results it should produce.
  function automatic void apply_operation(kind_e k, logic signed [31:0] v, int p);
    int idx;
    int n;
    idx = list_vals.size();
    case (k)
      K_CLEAR: begin
        list_vals.delete();
        pool_used = 0;
        expected_results.push_back(mk_result(1'b0, 0, 0, 1'b1));
      end
      K_ADD_HEAD, K_ADD_TAIL, K_ADD_AT: begin
        if (pool_used >= CAP) begin
          expected_results.push_back(mk_result(1'b1, 0, 0, 1'b1));
        end else begin
          pool_used++;
          if (k == K_ADD_HEAD) list_vals.push_front(v);
          else if (k == K_ADD_TAIL || p == 0 || p > list_vals.size()) list_vals.push_back(v);
          else list_vals.insert(p - 1, v);
          expected_results.push_back(mk_result(1'b0, 0, 0, 1'b1));
        end
      end
      K_FIND: begin
        foreach (list_vals[i]) if (list_vals[i] == v && idx == list_vals.size()) idx = i;
        expected_results.push_back(mk_result(1'b0, 0, idx + 1, 1'b1));
      end
      K_REMOVE: begin
        foreach (list_vals[i]) if (list_vals[i] == v && idx == list_vals.size()) idx = i;
        if (idx < list_vals.size()) list_vals.delete(idx);
        expected_results.push_back(mk_result(1'b0, 0, 0, 1'b1));
      end
      default: begin
        n = list_vals.size();
        if (n == 0) expected_results.push_back(mk_result(1'b0, 0, 0, 1'b1));
        for (int i = 0; i < n; i++)
          expected_results.push_back(mk_result(1'b0,
              (k == K_DUMP) ? list_vals[i] : list_vals[n - 1 - i], 0, i == n - 1));
      end
    endcase
  endfunction

  task automatic send_op(kind_e k, logic signed [31:0] v, int p);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.kind <= k;
    op_ch.value <= v;
    op_ch.position <= p[6:0];
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    apply_operation(k, v, p);
  endtask

  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t exp_r;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.status, res_ch.item_value, res_ch.found_position,
              res_ch.list_length, res_ch.last};
      if (expected_results.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.item_value !== exp_r.item_value) begin
          $error("item_value exp %0d got %0d", exp_r.item_value, got.item_value); errors++;
        end
        if (got.found_position !== exp_r.found_position) begin
          $error("found_position exp %0d got %0d", exp_r.found_position,
                 got.found_position); errors++;
        end
        if (got.list_length !== exp_r.list_length) begin
          $error("list_length exp %0d got %0d", exp_r.list_length, got.list_length);
          errors++;
        end
        if (got.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(K_FIND, 5, 0);
    send_op(K_DUMP, 0, 0);
    send_op(K_DUMP_REV, 0, 0);
    send_op(K_REMOVE, 5, 0);
    send_op(K_ADD_HEAD, 32'sh7fffffff, 0);
    send_op(K_ADD_TAIL, 32'sh80000000, 127);
    send_op(K_ADD_AT, -1, 1);
    send_op(K_ADD_AT, 0, 2);
    send_op(K_ADD_AT, 3, 0);
    send_op(K_ADD_AT, 4, 100);
    send_op(K_ADD_AT, 9, 64);
    send_op(K_FIND, 32'sh80000000, 0);
    send_op(K_FIND, 12345, 0);
    send_op(K_DUMP, 0, 0);
    send_op(K_DUMP_REV, 0, 0);
    send_op(K_REMOVE, -1, 0);
    send_op(K_REMOVE, 9, 0);
    send_op(K_REMOVE, 777, 0);
    send_op(K_DUMP, 0, 0);
    send_op(K_CLEAR, 0, 0);
    send_op(K_DUMP, 0, 0);
  endtask

  // Fills the whole pool, overflows it, and dumps a full list while the receiver stalls.
  task automatic test_pool_full();
    for (int i = 0; i < CAP + 3; i++)
      send_op(kind_e'($urandom_range(1, 3)), $urandom, $urandom_range(0, 70));
    hold_cycles = 400;
    send_op(K_DUMP, 0, 0);
    send_op(K_DUMP_REV, 0, 0);
    for (int i = 0; i < 6; i++) send_op(K_FIND, $urandom, 0);
    send_op(K_REMOVE, list_vals[CAP - 1], 0);
    send_op(K_FIND, list_vals[0], 0);
    send_op(K_CLEAR, 0, 0);
  endtask

  task automatic test_random();
    logic signed [31:0] v;
    int r;
    for (int i = 0; i < 200; i++) begin
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 1) != 0) ? pool_vals[$urandom_range(0, 7)] : $urandom;
      if (r < 2) send_op(K_CLEAR, $urandom, $urandom);
      else if (r < 45) send_op(kind_e'($urandom_range(1, 3)), v,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                           : $urandom_range(0, 20));
      else if (r < 65) send_op(K_FIND, v, $urandom);
      else if (r < 85) send_op(K_REMOVE, v, $urandom);
      else send_op(kind_e'($urandom_range(6, 7)), $urandom, $urandom);
    end
  endtask

  initial begin
    errors = 0;
    pool_used = 0;
    hold_cycles = 0;
    foreach (pool_vals[i]) pool_vals[i] = $urandom;
    op_ch.valid = 1'b0;
    op_ch.kind = K_CLEAR;
    op_ch.value = '0;
    op_ch.position = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pool_full();
    test_random();
    op_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/ole_pkg.sv
src/ole_in_if.sv
src/ole_out_if.sv
src/ole_ram.sv
src/ordered_list_engine_top.sv
src/ole_checker.sv
test/ordered_list_engine_top_tb.sv
